[design/alsd_pkg.sv]
// Shared types, codes and color tables for the LED strip driver.
package alsd_pkg;

   localparam int PIXELS_DEFAULT         = 256;
   localparam int DEFAULT_PIXELS_DEFAULT = 4;
   // pixel_index is eight bits wide, so no more than this many entries are ever addressed
   localparam int STORE_LIMIT            = 256;
   localparam int QUEUE_DEPTH            = 2;
   localparam int BITS_PER_PIXEL         = 24;

   // request opcodes
   localparam logic [2:0] OP_SET_RGB  = 3'd0;
   localparam logic [2:0] OP_SET_CODE = 3'd1;
   localparam logic [2:0] OP_CLEAR    = 3'd2;
   localparam logic [2:0] OP_FLUSH    = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   // command kinds after decode
   localparam logic [2:0] KIND_SET   = 3'd0;
   localparam logic [2:0] KIND_CLEAR = 3'd1;
   localparam logic [2:0] KIND_FLUSH = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_NOP   = 3'd4;

   // configuration register indexes
   localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
   localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
   localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
   localparam logic [2:0] REG_ONE_LOW   = 3'd3;
   localparam logic [2:0] REG_LATCH     = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic        wr_en;
      logic [7:0]  index;
      logic [23:0] word;   // green, red, blue
      logic [8:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  zero_high;
      logic [7:0]  zero_low;
      logic [7:0]  one_high;
      logic [7:0]  one_low;
      logic [15:0] latch;
   } cfg_type;

   function automatic logic [7:0] gamma3(input logic [2:0] code);
      logic [7:0] level;
      case (code)
         3'd0:    level = 8'd0;
         3'd1:    level = 8'd2;
         3'd2:    level = 8'd7;
         3'd3:    level = 8'd25;
         3'd4:    level = 8'd57;
         3'd5:    level = 8'd106;
         3'd6:    level = 8'd171;
         default: level = 8'd255;
      endcase
      return level;
   endfunction

   function automatic logic [7:0] gamma2(input logic [1:0] code);
      logic [7:0] level;
      case (code)
         2'd0:    level = 8'd0;
         2'd1:    level = 8'd2;
         2'd2:    level = 8'd57;
         default: level = 8'd255;
      endcase
      return level;
   endfunction

endpackage

[design/alsd_front.sv]
// Request decode: classify the opcode and build the pixel word.
module alsd_front #(
   parameter int PIXELS = alsd_pkg::PIXELS_DEFAULT
) (
   input  logic [2:0]        req_opcode,
   input  logic [7:0]        req_pixel_index,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_color_code,
   input  logic [8:0]        req_frame_count,
   output alsd_pkg::cmd_type cmd
);

   always_comb begin
      cmd.index = req_pixel_index;
      cmd.count = req_frame_count;
      cmd.wr_en = 32'(req_pixel_index) < PIXELS;
      cmd.word  = {req_green, req_red, req_blue};
      case (req_opcode)
         alsd_pkg::OP_SET_RGB: begin
            cmd.kind = alsd_pkg::KIND_SET;
         end
         alsd_pkg::OP_SET_CODE: begin
            cmd.kind = alsd_pkg::KIND_SET;
            cmd.word = {alsd_pkg::gamma3(req_color_code[4:2]),
                        alsd_pkg::gamma3(req_color_code[7:5]),
                        alsd_pkg::gamma2(req_color_code[1:0])};
         end
         alsd_pkg::OP_CLEAR: cmd.kind = alsd_pkg::KIND_CLEAR;
         alsd_pkg::OP_FLUSH: cmd.kind = alsd_pkg::KIND_FLUSH;
         alsd_pkg::OP_TICK:  cmd.kind = alsd_pkg::KIND_TICK;
         default:            cmd.kind = alsd_pkg::KIND_NOP;
      endcase
   end

endmodule

[design/alsd_queue.sv]
// Short command queue between the decode front and the line engine.
module alsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  alsd_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              pop_valid,
   output alsd_pkg::cmd_type pop_cmd,
   input  logic              pop
);

   localparam int PTR_W = $clog2(alsd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(alsd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(alsd_pkg::QUEUE_DEPTH - 1);

   alsd_pkg::cmd_type slot_ff [alsd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;

   assign full      = count_ff == CNT_W'(alsd_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign push      = push_valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/alsd_engine.sv]
// Line engine: pixel store, pulse sequencer and result register.
module alsd_engine #(
   parameter int PIXELS         = alsd_pkg::PIXELS_DEFAULT,
   parameter int DEFAULT_PIXELS = alsd_pkg::DEFAULT_PIXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  alsd_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  alsd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_line_level,
   output logic              rsp_busy_res,
   output logic              rsp_refused
);

   localparam int DEPTH  = (PIXELS < alsd_pkg::STORE_LIMIT) ? PIXELS : alsd_pkg::STORE_LIMIT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DEF_COUNT = (DEFAULT_PIXELS < DEPTH) ? DEFAULT_PIXELS : DEPTH;
   localparam logic [8:0] DEF_LEN  = 9'(DEF_COUNT);
   localparam logic [4:0] LAST_BIT = 5'(alsd_pkg::BITS_PER_PIXEL - 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;
   localparam logic [1:0] PH_LATCH = 2'd3;

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == '0) ? 16'd1 : v;
   endfunction

   logic [1:0]   phase_ff, phase_in;
   logic [15:0]  tick_cnt_ff, tick_cnt_in;
   logic [8:0]   pixel_ptr_ff, pixel_ptr_in;
   logic [4:0]   bit_ptr_ff, bit_ptr_in;
   logic [8:0]   frame_len_ff, frame_len_in;
   logic [8:0]   used_ff, used_in;
   logic [23:0]  cur_word_ff, cur_word_in;
   logic [23:0]  pix0_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [23:0]  mem [DEPTH];
   logic [23:0]  rd_data_ff;
   logic         rd_valid_ff;
   logic         rsp_valid_ff, rsp_level_ff, rsp_busy_ff, rsp_refused_ff;

   logic         advance, fire, busy;
   logic         store_we, clear_store;
   logic         res_level, res_busy, res_refused;
   logic [15:0]  cnt_dec;
   logic [8:0]   rd_addr;
   logic         rd_in_range;
   logic [23:0]  next_word;
   logic [8:0]   flush_len;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = q_valid && advance;
   assign q_pop       = fire;
   assign busy        = phase_ff != PH_IDLE;
   assign rd_addr     = pixel_ptr_ff + 9'd1;
   assign rd_in_range = 32'(rd_addr) < DEPTH;
   assign next_word   = rd_valid_ff ? rd_data_ff : '0;
   assign flush_len   = (q_cmd.count > used_ff) ? used_ff : q_cmd.count;

   always_comb begin
      phase_in     = phase_ff;
      tick_cnt_in  = tick_cnt_ff;
      pixel_ptr_in = pixel_ptr_ff;
      bit_ptr_in   = bit_ptr_ff;
      frame_len_in = frame_len_ff;
      used_in      = used_ff;
      cur_word_in  = cur_word_ff;
      store_we     = 1'b0;
      clear_store  = 1'b0;
      res_level    = 1'b0;
      res_busy     = 1'b0;
      res_refused  = 1'b0;
      cnt_dec      = (tick_cnt_ff != '0) ? tick_cnt_ff - 16'd1 : tick_cnt_ff;
      if (fire) begin
         case (q_cmd.kind)
            alsd_pkg::KIND_TICK: begin
               if (busy) begin
                  res_busy    = 1'b1;
                  res_level   = phase_ff == PH_HIGH;
                  tick_cnt_in = cnt_dec;
                  if (cnt_dec == '0) begin
                     case (phase_ff)
                        PH_HIGH: begin
                           phase_in    = PH_LOW;
                           tick_cnt_in = at_least_one({8'd0, cur_word_ff[23] ? cfg.one_low
                                                                             : cfg.zero_low});
                        end
                        PH_LOW: begin
                           if (bit_ptr_ff == LAST_BIT) begin
                              bit_ptr_in   = '0;
                              pixel_ptr_in = pixel_ptr_ff + 9'd1;
                              cur_word_in  = next_word;
                           end else begin
                              bit_ptr_in  = bit_ptr_ff + 5'd1;
                              cur_word_in = {cur_word_ff[22:0], 1'b0};
                           end
                           if (pixel_ptr_in < frame_len_ff) begin
                              phase_in    = PH_HIGH;
                              tick_cnt_in = at_least_one({8'd0, cur_word_in[23] ? cfg.one_high
                                                                                : cfg.zero_high});
                           end else begin
                              phase_in    = PH_LATCH;
                              tick_cnt_in = at_least_one(cfg.latch);
                           end
                        end
                        default: begin
                           // latch finished: back to idle
                           phase_in     = PH_IDLE;
                           frame_len_in = '0;
                           pixel_ptr_in = '0;
                           bit_ptr_in   = '0;
                        end
                     endcase
                  end
               end
            end
            alsd_pkg::KIND_SET: begin
               res_busy = busy;
               if (busy) begin
                  res_refused = 1'b1;
               end else if (q_cmd.wr_en) begin
                  store_we = 1'b1;
                  if ({1'b0, q_cmd.index} >= used_ff) begin
                     used_in = {1'b0, q_cmd.index} + 9'd1;
                  end
               end
            end
            alsd_pkg::KIND_CLEAR: begin
               res_busy = 1'b1;
               if (busy) begin
                  res_refused = 1'b1;
               end else begin
                  clear_store  = 1'b1;
                  used_in      = DEF_LEN;
                  frame_len_in = DEF_LEN;
                  pixel_ptr_in = '0;
                  bit_ptr_in   = '0;
                  cur_word_in  = '0;
                  if (DEF_LEN != '0) begin
                     phase_in    = PH_HIGH;
                     tick_cnt_in = at_least_one({8'd0, cfg.zero_high});
                  end else begin
                     phase_in    = PH_LATCH;
                     tick_cnt_in = at_least_one(cfg.latch);
                  end
               end
            end
            alsd_pkg::KIND_FLUSH: begin
               res_busy = 1'b1;
               if (busy) begin
                  res_refused = 1'b1;
               end else begin
                  frame_len_in = flush_len;
                  pixel_ptr_in = '0;
                  bit_ptr_in   = '0;
                  cur_word_in  = pix0_ff;
                  if (flush_len != '0) begin
                     phase_in    = PH_HIGH;
                     tick_cnt_in = at_least_one({8'd0, pix0_ff[23] ? cfg.one_high
                                                                   : cfg.zero_high});
                  end else begin
                     phase_in    = PH_LATCH;
                     tick_cnt_in = at_least_one(cfg.latch);
                  end
               end
            end
            default: begin
               res_busy = busy;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_cnt_ff  <= '0;
         pixel_ptr_ff <= '0;
         bit_ptr_ff   <= '0;
         frame_len_ff <= '0;
         used_ff      <= '0;
         cur_word_ff  <= '0;
         pix0_ff      <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_cnt_ff  <= tick_cnt_in;
         pixel_ptr_ff <= pixel_ptr_in;
         bit_ptr_ff   <= bit_ptr_in;
         frame_len_ff <= frame_len_in;
         used_ff      <= used_in;
         cur_word_ff  <= cur_word_in;
         if (clear_store) begin
            valid_ff <= '0;
            pix0_ff  <= '0;
         end else if (store_we) begin
            valid_ff[q_cmd.index[ADDR_W-1:0]] <= 1'b1;
            if (q_cmd.index == '0) begin
               pix0_ff <= q_cmd.word;
            end
         end
         rd_valid_ff <= rd_in_range && valid_ff[rd_addr[ADDR_W-1:0]];
         if (advance) begin
            rsp_valid_ff <= q_valid;
         end
      end
   end

   // store write port and the look-ahead read of the next pixel
   always_ff @(posedge clock) begin
      if (store_we) begin
         mem[q_cmd.index[ADDR_W-1:0]] <= q_cmd.word;
      end
      if (rd_in_range) begin
         rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_level_ff   <= res_level;
         rsp_busy_ff    <= res_busy;
         rsp_refused_ff <= res_refused;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_level_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_refused    = rsp_refused_ff;

   a_idle_pointers: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (pixel_ptr_ff == '0 && bit_ptr_ff == '0))
      else $error("pointers not parked while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ptr_ff <= LAST_BIT)
      else $error("bit pointer past last bit of pixel");

   a_pixel_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HIGH || phase_ff == PH_LOW) |-> pixel_ptr_ff < frame_len_ff)
      else $error("bit pulse outside the frame");

   a_frame_clamped: assert property (@(posedge clock) disable iff (reset)
      frame_len_ff <= used_ff)
      else $error("frame longer than used count");

   a_counter_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> tick_cnt_ff != '0)
      else $error("pulse running with empty tick counter");

endmodule

[design/addressable_led_strip_driver.sv]
// Top level of the addressable LED strip driver: register file, decode, queue and line engine.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   opcode, pixel_index, red, green, blue,
//                                         color_code, frame_count
//   rsp      out        rsp_valid/stall   line_level, busy_res, refused
//   csr      in         csr_valid/ready   index (3 bits), data (16 bits)
//
// One transaction enters and one result leaves per clock cycle while rsp_stall is low; a
// request passes through a queue slot, then the result register, before its result appears.
// The pixel store's read port runs one pixel ahead of the line, so no tick waits
// on a store read. Reset is synchronous: it clears the store's entry flags at once,
// so the whole store reads as zero with no clearing pass. A held rsp_stall freezes
// a valid result in the result register; the two-entry queue absorbs the gap and
// req_stall rises only when it is full. csr writes are always taken (csr_ready high).
module addressable_led_strip_driver #(
   parameter int PIXELS         = alsd_pkg::PIXELS_DEFAULT,
   parameter int DEFAULT_PIXELS = alsd_pkg::DEFAULT_PIXELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pixel_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_color_code,
   input  logic [8:0]  req_frame_count,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_level,
   output logic        rsp_busy_res,
   output logic        rsp_refused,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   alsd_pkg::cfg_type cfg_ff;
   alsd_pkg::cmd_type front_cmd;
   alsd_pkg::cmd_type q_cmd;
   logic              q_valid;
   logic              q_pop;
   logic              q_full;

   // Register file: writes land at once; a pulse picks up its length when it starts.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high <= 8'd3;
         cfg_ff.zero_low  <= 8'd9;
         cfg_ff.one_high  <= 8'd9;
         cfg_ff.one_low   <= 8'd3;
         cfg_ff.latch     <= 16'd500;
      end else if (csr_valid) begin
         case (csr_index)
            alsd_pkg::REG_ZERO_HIGH: cfg_ff.zero_high <= csr_data[7:0];
            alsd_pkg::REG_ZERO_LOW:  cfg_ff.zero_low  <= csr_data[7:0];
            alsd_pkg::REG_ONE_HIGH:  cfg_ff.one_high  <= csr_data[7:0];
            alsd_pkg::REG_ONE_LOW:   cfg_ff.one_low   <= csr_data[7:0];
            alsd_pkg::REG_LATCH:     cfg_ff.latch     <= csr_data;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   // Front: classify the opcode and expand the color before queueing.
   alsd_front #(
      .PIXELS (PIXELS)
   ) u_front (
      .req_opcode      (req_opcode),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_color_code  (req_color_code),
      .req_frame_count (req_frame_count),
      .cmd             (front_cmd)
   );

   // Queue: hold decoded transactions while the result side stalls.
   alsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   assign req_stall = q_full;

   // Back: one command per cycle while the result side is not stalled, against the store and the pulse sequencer.
   alsd_engine #(
      .PIXELS         (PIXELS),
      .DEFAULT_PIXELS (DEFAULT_PIXELS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_refused    (rsp_refused)
   );

endmodule

[dv/tb.sv]
// Self-checking testbench for the addressable LED strip driver.
module tb;

   // Opcodes and register indexes that the block must ignore.
   localparam logic [2:0] OP_SPARE_FIRST  = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST   = 3'd7;
   localparam logic [2:0] REG_SPARE_FIRST = alsd_pkg::REG_LATCH + 3'd1;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   localparam int STRIP_PIXELS   = alsd_pkg::PIXELS_DEFAULT;
   localparam int STRIP_DEFAULT  = alsd_pkg::DEFAULT_PIXELS_DEFAULT;
   localparam int RANDOM_ITEMS   = 580;
   localparam int HOLD_OFF       = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 100;

   // Gamma levels packed low entry first: three-bit and two-bit channel codes.
   localparam logic [63:0] GAMMA3_LEVELS =
      {8'd255, 8'd171, 8'd106, 8'd57, 8'd25, 8'd7, 8'd2, 8'd0};
   localparam logic [31:0] GAMMA2_LEVELS = {8'd255, 8'd57, 8'd2, 8'd0};

   typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] color_code;
      logic [8:0] frame_count;
   } led_cmd_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic refused;
   } led_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [7:0]  req_pixel_index;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic [7:0]  req_color_code;
   logic [8:0]  req_frame_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic        rsp_refused;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   addressable_led_strip_driver u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_color_code  (req_color_code),
      .req_frame_count (req_frame_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_level  (rsp_line_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_refused     (rsp_refused),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ------------------------------------------------------------------
   // Strip predictor: pixel store, frame walk and timing registers.
   // ------------------------------------------------------------------
   logic [23:0]       strip_pixels [STRIP_PIXELS];
   logic [8:0]        strip_used;
   logic [8:0]        strip_frame_len;
   logic [8:0]        strip_pix_ptr;
   logic [4:0]        strip_bit_ptr;
   line_phase_type    strip_phase;
   logic [15:0]       strip_ticks_left;
   alsd_pkg::cfg_type strip_cfg;

   led_result_type expected_leds [$];
   led_result_type checked_result;
   int             fail_count = 0;
   int             items_sent = 0;
   bit             no_gaps = 1'b0;
   int             rsp_hold_left = 0;
   int             stall_burst = 0;
   int             quiet_cycles = 0;

   // A pulse length of zero still lasts one tick.
   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   // Bit of the current pixel under the bit pointer, most significant first.
   function automatic logic current_bit();
      if (strip_pix_ptr < STRIP_PIXELS) begin
         return strip_pixels[strip_pix_ptr[7:0]][23 - strip_bit_ptr];
      end
      return 1'b0;
   endfunction

   // Start the next bit's high pulse, or the latch once the frame is out.
   function automatic void begin_pulse();
      if (strip_pix_ptr < strip_frame_len) begin
         strip_phase      = LINE_HIGH;
         strip_ticks_left = at_least_one({8'd0, current_bit() ? strip_cfg.one_high
                                                              : strip_cfg.zero_high});
      end else begin
         strip_phase      = LINE_LATCH;
         strip_ticks_left = at_least_one(strip_cfg.latch);
      end
   endfunction

   function automatic void store_pixel(input int idx, input logic [23:0] word);
      if (idx < STRIP_PIXELS) begin
         strip_pixels[idx] = word;
         if (idx >= strip_used) begin
            strip_used = 9'(idx + 1);
         end
      end
   endfunction

   // Clamp the frame to the pixels in use and launch its first pulse.
   function automatic void launch_frame(input int count);
      if (count > strip_used) begin
         count = strip_used;
      end
      strip_frame_len = 9'(count);
      strip_pix_ptr   = 9'd0;
      strip_bit_ptr   = 5'd0;
      begin_pulse();
   endfunction

   function automatic void strip_reset();
      for (int i = 0; i < STRIP_PIXELS; i++) begin
         strip_pixels[i] = 24'd0;
      end
      strip_used          = 9'd0;
      strip_frame_len     = 9'd0;
      strip_pix_ptr       = 9'd0;
      strip_bit_ptr       = 5'd0;
      strip_phase         = LINE_IDLE;
      strip_ticks_left    = 16'd0;
      strip_cfg.zero_high = 8'd3;
      strip_cfg.zero_low  = 8'd9;
      strip_cfg.one_high  = 8'd9;
      strip_cfg.one_low   = 8'd3;
      strip_cfg.latch     = 16'd500;
   endfunction

   // Advance the predictor by one transaction and return the result it causes.
   function automatic led_result_type predict_led(input led_cmd_type c);
      led_result_type r;
      logic           was_busy;
      logic [7:0]     g_lvl;
      logic [7:0]     r_lvl;
      logic [7:0]     b_lvl;
      r        = '0;
      was_busy = strip_phase != LINE_IDLE;
      if (c.opcode == alsd_pkg::OP_TICK) begin
         if (was_busy) begin
            r.busy_res   = 1'b1;
            r.line_level = strip_phase == LINE_HIGH;
            if (strip_ticks_left != 16'd0) begin
               strip_ticks_left--;
            end
            if (strip_ticks_left == 16'd0) begin
               case (strip_phase)
                  LINE_HIGH: begin
                     strip_phase      = LINE_LOW;
                     strip_ticks_left = at_least_one({8'd0, current_bit() ? strip_cfg.one_low
                                                                          : strip_cfg.zero_low});
                  end
                  LINE_LOW: begin
                     if (strip_bit_ptr == alsd_pkg::BITS_PER_PIXEL - 1) begin
                        strip_bit_ptr = 5'd0;
                        strip_pix_ptr = strip_pix_ptr + 9'd1;
                     end else begin
                        strip_bit_ptr = strip_bit_ptr + 5'd1;
                     end
                     begin_pulse();
                  end
                  default: begin
                     // latch over: the line goes idle
                     strip_phase     = LINE_IDLE;
                     strip_frame_len = 9'd0;
                     strip_pix_ptr   = 9'd0;
                     strip_bit_ptr   = 5'd0;
                  end
               endcase
            end
         end
      end else if (c.opcode <= alsd_pkg::OP_FLUSH) begin
         if (was_busy) begin
            r.refused = 1'b1;
         end else begin
            case (c.opcode)
               alsd_pkg::OP_SET_RGB: begin
                  store_pixel(int'(c.pixel_index), {c.green, c.red, c.blue});
               end
               alsd_pkg::OP_SET_CODE: begin
                  r_lvl = GAMMA3_LEVELS[c.color_code[7:5] * 8 +: 8];
                  g_lvl = GAMMA3_LEVELS[c.color_code[4:2] * 8 +: 8];
                  b_lvl = GAMMA2_LEVELS[c.color_code[1:0] * 8 +: 8];
                  store_pixel(int'(c.pixel_index), {g_lvl, r_lvl, b_lvl});
               end
               alsd_pkg::OP_CLEAR: begin
                  for (int i = 0; i < STRIP_PIXELS; i++) begin
                     strip_pixels[i] = 24'd0;
                  end
                  strip_used = 9'd0;
                  for (int i = 0; i < STRIP_DEFAULT; i++) begin
                     store_pixel(i, 24'd0);
                  end
                  launch_frame(STRIP_DEFAULT);
               end
               default: begin
                  launch_frame(int'(c.frame_count));
               end
            endcase
         end
         r.busy_res = strip_phase != LINE_IDLE;
      end else begin
         r.busy_res = was_busy;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset and mismatch reporting
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic got, input logic wanted);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, wanted);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall bursts, plus a long hold-off on request.
   // ------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else if (no_gaps) begin
            rsp_stall   <= 1'b0;
            stall_burst = 0;
         end else if (stall_burst > 0) begin
            rsp_stall <= 1'b1;
            stall_burst--;
         end else if ($urandom_range(0, 9) == 0) begin
            // hold this cycle and start a stall burst of random length
            rsp_stall   <= 1'b1;
            stall_burst = $urandom_range(0, 15);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every accepted result with the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_leds.size() == 0) begin
            report_mismatch("result with nothing expected", 1'b1, 1'b0);
         end else begin
            checked_result = expected_leds.pop_front();
            if (rsp_line_level !== checked_result.line_level) begin
               report_mismatch("line_level", rsp_line_level, checked_result.line_level);
            end
            if (rsp_busy_res !== checked_result.busy_res) begin
               report_mismatch("busy_res", rsp_busy_res, checked_result.busy_res);
            end
            if (rsp_refused !== checked_result.refused) begin
               report_mismatch("refused", rsp_refused, checked_result.refused);
            end
         end
      end
   end

   // Watchdog: end the run when no channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("addressable_led_strip_driver: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic led_cmd_type make_item(input logic [2:0] op, input logic [7:0] idx,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] code,
                                             input logic [8:0] count);
      led_cmd_type c;
      c.opcode      = op;
      c.pixel_index = idx;
      c.red         = r;
      c.green       = g;
      c.blue        = b;
      c.color_code  = code;
      c.frame_count = count;
      return c;
   endfunction

   // Opcode as given, every other field random: the block must not care.
   function automatic led_cmd_type scrambled_cmd(input logic [2:0] op);
      return make_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 9'($urandom_range(0, 256)));
   endfunction

   // Mostly ticks while a frame runs, with a few other opcodes thrown in (set, clear and flush are refused);
   // while idle, edits, flushes and clears that start the next frame, plus idle ticks and spare opcodes.
   function automatic led_cmd_type random_cmd();
      led_cmd_type c;
      int          roll;
      roll = $urandom_range(0, 99);
      if (strip_phase != LINE_IDLE) begin
         c = scrambled_cmd(roll < 93 ? alsd_pkg::OP_TICK
                                     : 3'($urandom_range(alsd_pkg::OP_SET_RGB, OP_SPARE_LAST)));
      end else if (roll < 30) begin
         c = scrambled_cmd(alsd_pkg::OP_SET_RGB);
      end else if (roll < 50) begin
         c = scrambled_cmd(alsd_pkg::OP_SET_CODE);
      end else if (roll < 65) begin
         c = scrambled_cmd(alsd_pkg::OP_FLUSH);
      end else if (roll < 70) begin
         c = scrambled_cmd(alsd_pkg::OP_CLEAR);
      end else if (roll < 95) begin
         c = scrambled_cmd(alsd_pkg::OP_TICK);
      end else begin
         c = scrambled_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
      end
      if ($urandom_range(0, 1) == 0) begin
         c.pixel_index = 8'($urandom_range(0, 15));
      end
      // keep frames short; now and then a long one
      if ($urandom_range(0, 63) != 0) begin
         c.frame_count = 9'($urandom_range(0, 6));
      end
      return c;
   endfunction

   // Offer one transaction, hold it until accepted, then log its expectation.
   // Valid stays high, unless a random gap is drawn, so a following call can offer the next one back to back.
   task automatic send_item(input led_cmd_type c);
      req_valid       <= 1'b1;
      req_opcode      <= c.opcode;
      req_pixel_index <= c.pixel_index;
      req_red         <= c.red;
      req_green       <= c.green;
      req_blue        <= c.blue;
      req_color_code  <= c.color_code;
      req_frame_count <= c.frame_count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_leds.push_back(predict_led(c));
      items_sent++;
      if (!no_gaps && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Tick until the predictor says the frame and its latch are over.
   task automatic run_frame_out();
      while (strip_phase != LINE_IDLE) send_item(scrambled_cmd(alsd_pkg::OP_TICK));
   endtask

   // Write one register; call only with no transaction in flight.
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         alsd_pkg::REG_ZERO_HIGH: strip_cfg.zero_high = data[7:0];
         alsd_pkg::REG_ZERO_LOW:  strip_cfg.zero_low  = data[7:0];
         alsd_pkg::REG_ONE_HIGH:  strip_cfg.one_high  = data[7:0];
         alsd_pkg::REG_ONE_LOW:   strip_cfg.one_low   = data[7:0];
         alsd_pkg::REG_LATCH:     strip_cfg.latch     = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_timing(input logic [7:0] zh, input logic [7:0] zl,
                               input logic [7:0] oh, input logic [7:0] ol,
                               input logic [15:0] latch);
      drain_results();
      write_csr(alsd_pkg::REG_ZERO_HIGH, {8'd0, zh});
      write_csr(alsd_pkg::REG_ZERO_LOW, {8'd0, zl});
      write_csr(alsd_pkg::REG_ONE_HIGH, {8'd0, oh});
      write_csr(alsd_pkg::REG_ONE_LOW, {8'd0, ol});
      write_csr(alsd_pkg::REG_LATCH, latch);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Idle ticks, spare opcodes and writes to indexes past the last register.
   task automatic test_idle_commands();
      apply_timing(8'd1, 8'd2, 8'd2, 8'd1, 16'd3);
      write_csr(REG_SPARE_FIRST, 16'hffff);
      write_csr(REG_SPARE_LAST, 16'h0000);
      send_item(scrambled_cmd(alsd_pkg::OP_TICK));
      send_item(scrambled_cmd(OP_SPARE_FIRST));
      send_item(scrambled_cmd(OP_SPARE_FIRST + 3'd1));
      send_item(scrambled_cmd(OP_SPARE_LAST));
   endtask

   // A flush with nothing in use sends the latch alone; edits are refused meanwhile.
   task automatic test_refusals();
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd256));
      send_item(make_item(alsd_pkg::OP_SET_RGB, 8'd7, 8'hff, 8'hff, 8'hff, 8'd0, 9'd0));
      send_item(make_item(alsd_pkg::OP_SET_CODE, 8'd7, 8'd0, 8'd0, 8'd0, 8'hff, 9'd0));
      send_item(scrambled_cmd(alsd_pkg::OP_CLEAR));
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd1));
      send_item(scrambled_cmd(OP_SPARE_LAST));
      run_frame_out();
   endtask

   // Both set forms, flush clamping, clear with its default frame, last pixel.
   task automatic test_pixel_frames();
      apply_timing(8'd1, 8'd1, 8'd2, 8'd1, 16'd2);
      send_item(make_item(alsd_pkg::OP_SET_RGB, 8'd0, 8'hff, 8'h00, 8'ha5, 8'h00, 9'd0));
      send_item(make_item(alsd_pkg::OP_SET_CODE, 8'd1, 8'h00, 8'hff, 8'h00, 8'hff, 9'd0));
      send_item(make_item(alsd_pkg::OP_SET_CODE, 8'd2, 8'hff, 8'hff, 8'hff, 8'h00, 9'd0));
      send_item(make_item(alsd_pkg::OP_SET_CODE, 8'd3, 8'h00, 8'h00, 8'h00, 8'h69, 9'd0));
      // asks for nine, only four are in use
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd9));
      run_frame_out();
      send_item(make_item(alsd_pkg::OP_SET_RGB, 8'd255, 8'h00, 8'hff, 8'h00, 8'd0, 9'd0));
      send_item(scrambled_cmd(alsd_pkg::OP_CLEAR));
      run_frame_out();
      send_item(make_item(alsd_pkg::OP_SET_RGB, 8'd255, 8'h12, 8'h34, 8'h56, 8'd0, 9'd0));
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0));
      run_frame_out();
   endtask

   // Zero lengths act as one tick; then the longest high pulse, shortened behind it.
   task automatic test_register_extremes();
      apply_timing(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
      send_item(make_item(alsd_pkg::OP_SET_RGB, 8'd0, 8'h55, 8'haa, 8'hf0, 8'd0, 9'd0));
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd1));
      run_frame_out();
      apply_timing(8'd255, 8'd255, 8'd255, 8'd255, 16'hffff);
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd1));
      apply_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
      run_frame_out();
   endtask

   // New lengths mid-frame: a pulse keeps the lengths it started with.
   task automatic test_midframe_retiming();
      apply_timing(8'd2, 8'd3, 8'd4, 8'd5, 16'd6);
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd2));
      repeat (20) send_item(scrambled_cmd(alsd_pkg::OP_TICK));
      apply_timing(8'd1, 8'd6, 8'd3, 8'd2, 16'd4);
      repeat (15) send_item(scrambled_cmd(alsd_pkg::OP_TICK));
      apply_timing(8'd1, 8'd1, 8'd2, 8'd1, 16'd9);
      run_frame_out();
   endtask

   // Hold the result side for a long stretch while ticks keep coming, so the
   // queue fills and the block has to stall its request side.
   task automatic test_backpressure();
      send_item(make_item(alsd_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd2));
      rsp_hold_left = HOLD_OFF;
      repeat (60) send_item(scrambled_cmd(alsd_pkg::OP_TICK));
      run_frame_out();
   endtask

   // Random traffic in four timing settings; the third phase runs without gaps.
   task automatic test_random_traffic();
      int budget;
      for (int phase = 0; phase < 4; phase++) begin
         apply_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                      8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                      16'($urandom_range(1, 16)));
         no_gaps = (phase == 2);
         budget  = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < budget) send_item(random_cmd());
      end
      no_gaps = 1'b0;
   endtask

   // Closing stretch: back-to-back traffic with no idling on either side.
   task automatic test_steady_stream();
      apply_timing(8'd2, 8'd1, 8'd1, 8'd2, 16'd3);
      no_gaps = 1'b1;
      repeat (300) send_item(random_cmd());
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = alsd_pkg::OP_TICK;
      req_pixel_index = 8'd0;
      req_red         = 8'd0;
      req_green       = 8'd0;
      req_blue        = 8'd0;
      req_color_code  = 8'd0;
      req_frame_count = 9'd0;
      csr_valid       = 1'b0;
      csr_index       = alsd_pkg::REG_ZERO_HIGH;
      csr_data        = 16'd0;
      strip_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_commands();
      test_refusals();
      test_pixel_frames();
      test_register_extremes();
      test_midframe_retiming();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();

      // Let the last results come home, then call it.
      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("addressable_led_strip_driver: match");
      end else begin
         $display("addressable_led_strip_driver: mismatch");
      end
      $finish;
   end

endmodule
